// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the pitch shifter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLPS_CHECK(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pitch shifter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLPS_CHECK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pitch shifter check failed");

`endif

// File: design/dlps_pkg.sv
// ----------------------------------------------------------------------------
// dlps_pkg
// Types, constants and the crossfade gain function of the pitch shifter.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int DEF_LINE_DEPTH   = 32768;
    localparam int DEF_MAX_CHANNELS = 2;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RATIO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LENGTH   = 3'd4;

    localparam int RATIO_W = 18;
    localparam int CHCNT_W = 2;
    localparam int DLEN_W  = 16;
    localparam int FADE_W  = 13;

    localparam int unsigned MIN_LEN   = 4096;
    localparam int unsigned MIN_FADE  = 512;
    localparam int unsigned MAX_FADE  = 4096;
    localparam int unsigned RATIO_ONE = 65536;
    localparam int unsigned RATIO_MIN = 32768;
    localparam int unsigned RATIO_MAX = 131072;

    // Crossfade phase and gains.
    localparam int PHASE_W   = 17;
    localparam int GAIN_W    = 16;
    localparam int DIV_CNT_W = 5;

    // Head distance limits: floor(len * 65536 * N / 100), split into an exact
    // integer part and a remainder divided through a reciprocal.
    localparam int unsigned TH_DEN    = 100;
    localparam int unsigned NUM_NEAR  = 65536 * 8;
    localparam int unsigned NUM_FAR   = 65536 * 42;
    localparam int unsigned Q_NEAR    = NUM_NEAR / TH_DEN;
    localparam int unsigned R_NEAR    = NUM_NEAR % TH_DEN;
    localparam int unsigned Q_FAR     = NUM_FAR / TH_DEN;
    localparam int unsigned R_FAR     = NUM_FAR % TH_DEN;
    localparam int          RECIP_SH  = 32;
    localparam logic [63:0] RECIP     = ((64'd1 << RECIP_SH) + 64'd99) / 64'd100;
    localparam int          TH_Y_W    = 24;

    localparam logic [GAIN_W-1:0] QSINE [17] = '{
        16'd0,     16'd3212,  16'd6393,  16'd9512,  16'd12540, 16'd15447,
        16'd18205, 16'd20788, 16'd23170, 16'd25330, 16'd27246, 16'd28899,
        16'd30274, 16'd31357, 16'd32138, 16'd32610, 16'd32768
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_ch0;
        logic signed [SAMPLE_BITS-1:0] sample_ch1;
        logic                          block_end;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_ch0;
        logic signed [SAMPLE_BITS-1:0] out_ch1;
        logic                          block_end_out;
    } result_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Equal-power gain in unsigned Q1.15 from a quarter-sine table with linear
    // interpolation on the low 12 phase bits.
    function automatic logic [GAIN_W-1:0] gain(input logic [PHASE_W-1:0] ph);
        logic [4:0]        seg;
        logic [11:0]       fr;
        logic [GAIN_W-1:0] lo;
        logic [GAIN_W-1:0] hi;
        logic [27:0]       prod;
        logic [GAIN_W-1:0] g;
        seg = ph[16:12];
        fr  = ph[11:0];
        lo  = '0;
        hi  = '0;
        prod = '0;
        if (seg[4])
        begin
            g = QSINE[16];
        end
        else
        begin
            lo   = QSINE[seg];
            hi   = QSINE[seg + 5'd1];
            prod = 28'(hi - lo) * 28'(fr);
            g    = lo + GAIN_W'(prod >> 12);
        end
        return g;
    endfunction

endpackage

// File: design/dlps_line_mem.sv
// ----------------------------------------------------------------------------
// dlps_line_mem
// Single-port synchronous delay line memory with registered read data.
// ----------------------------------------------------------------------------
module dlps_line_mem #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: design/dlps_phase_div.sv
// ----------------------------------------------------------------------------
// dlps_phase_div
// Restoring divider for the crossfade phase, one quotient bit per cycle:
// quotient = floor(numer * 65536 / denom) with numer <= denom.
// ----------------------------------------------------------------------------
module dlps_phase_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dlps_pkg::FADE_W-1:0]   numer,
    input  logic [dlps_pkg::FADE_W-1:0]   denom,
    output dlps_pkg::div_status_t         status,
    output logic [dlps_pkg::PHASE_W-1:0]  quotient
);
    import dlps_pkg::*;

    logic [FADE_W:0]    rem_reg;
    logic [FADE_W-1:0]  den_reg;
    logic [PHASE_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic               ge;
    logic [FADE_W:0]    diff;

    assign ge   = rem_reg >= {1'b0, den_reg};
    assign diff = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            quo_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= {1'b0, numer};
            den_reg  <= denom;
            quo_reg  <= '0;
            cnt_reg  <= DIV_CNT_W'(PHASE_W - 1);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[PHASE_W-2:0], ge};
            rem_reg <= {diff[FADE_W-1:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// File: design/delay_line_pitch_shifter.sv
// ----------------------------------------------------------------------------
// delay_line_pitch_shifter
// Two-head delay line pitch shifter with equal-power crossfade.
// ----------------------------------------------------------------------------
// Each transfer on the frame channel carries one audio frame. While pitch
// shifting is active the frame is written into a circular delay line held in
// one single-port memory, and the active read head fetches the two
// neighboring frames around its fractional position and interpolates them.
// During a crossfade the idle head is read as well and both taps are mixed
// with sine/cosine gains. Since every sample write and every tap read uses
// the one memory port, the channels in use are handled in turn; during a
// crossfade a frame also waits for the 17-step phase divider and reads its
// taps twice. A bypassed frame (block disabled or ratio exactly 1.0) goes
// straight to the output register, skipping the memory. The output register
// frees the frame side while a result transfer is pending.
// After reset, and after any configuration write that toggles enabled or
// changes the effective line length, all LINE_DEPTH * MAX_CHANNELS memory
// entries are cleared one entry a cycle; no frame is taken meanwhile, while
// configuration writes are still accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delay_line_pitch_shifter #(
    parameter int LINE_DEPTH   = dlps_pkg::DEF_LINE_DEPTH,
    parameter int MAX_CHANNELS = dlps_pkg::DEF_MAX_CHANNELS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dlps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dlps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              frame_valid,
    output logic                              frame_stall,
    input  dlps_pkg::frame_t                  frame,
    output logic                              result_valid,
    input  logic                              result_stall,
    output dlps_pkg::result_t                 result
);
    import dlps_pkg::*;

    localparam int IDX_W     = $clog2(LINE_DEPTH);
    localparam int LEN_W     = IDX_W + 1;
    localparam int POS_W     = IDX_W + 16;
    localparam int LQ_W      = POS_W + 1;
    localparam int MEM_DEPTH = LINE_DEPTH * MAX_CHANNELS;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int TAP_W     = SAMPLE_BITS + 19;
    localparam int ACC_W     = TAP_W + GAIN_W + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_GAIN, S_RD0, S_RD1, S_RD2, S_RD3, S_MIX,
        S_UPD1, S_UPD2, S_UPD3, S_DONE
    } state_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [DLEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (int'(v) < int'(MIN_LEN))
            r = LEN_W'(MIN_LEN);
        else if (int'(v) > LINE_DEPTH)
            r = LEN_W'(LINE_DEPTH);
        else
            r = LEN_W'(v);
        return r;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] idx,
                                              input logic ch);
        return AW'(int'(idx) * MAX_CHANNELS + int'(ch));
    endfunction

    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                 input logic [RATIO_W-1:0] step,
                                                 input logic [LQ_W-1:0] lq_in);
        logic [LQ_W-1:0] s;
        s = LQ_W'(pos) + LQ_W'(step);
        if (s >= lq_in)
            s = s - lq_in;
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
        logic signed [SAMPLE_BITS-1:0] r;
        if (v > ACC_W'((1 << (SAMPLE_BITS - 1)) - 1))
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (v < -ACC_W'(1 << (SAMPLE_BITS - 1)))
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    // Configuration registers.
    logic                 enabled_reg;
    logic [RATIO_W-1:0]   pitch_ratio_reg;
    logic [CHCNT_W-1:0]   channel_count_reg;
    logic [DLEN_W-1:0]    delay_length_reg;
    logic [FADE_W-1:0]    fade_length_reg;

    // Line state.
    logic [IDX_W-1:0]     wi_reg;
    logic [POS_W-1:0]     head_a_reg;
    logic [POS_W-1:0]     head_b_reg;
    logic [FADE_W-1:0]    fade_rem_reg;
    logic                 active_reg;
    logic                 clearing_reg;
    logic [AW-1:0]        clr_cnt_reg;

    // Frame sequencing.
    state_t               state_reg;
    logic signed [SAMPLE_BITS-1:0] s0_reg;
    logic signed [SAMPLE_BITS-1:0] s1_reg;
    logic                 be_reg;
    logic                 stereo_reg;
    logic                 fading_reg;
    logic                 ch_reg;
    logic                 hsel_reg;
    logic signed [SAMPLE_BITS-1:0] v0_reg;
    logic signed [SAMPLE_BITS-1:0] v1_reg;
    logic signed [TAP_W-2:0] p0_reg;
    logic signed [TAP_W-1:0] tap_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [GAIN_W-1:0]    g_old_reg;
    logic [GAIN_W-1:0]    g_new_reg;
    logic [LQ_W-1:0]      dist_reg;
    logic signed [SAMPLE_BITS-1:0] res0_reg;
    logic signed [SAMPLE_BITS-1:0] res1_reg;
    logic                 result_valid_reg;
    result_t              result_reg;

    // Distance limits, recomputed from the line length in two stages.
    logic [LQ_W-1:0]      near_base_reg;
    logic [LQ_W-1:0]      far_base_reg;
    logic [TH_Y_W-1:0]    near_y_reg;
    logic [TH_Y_W-1:0]    far_y_reg;
    logic [LQ_W-1:0]      near_th_reg;
    logic [LQ_W-1:0]      far_th_reg;

    // Derived values.
    logic [LEN_W-1:0]     len_eff;
    logic [LQ_W-1:0]      lq;
    logic [FADE_W-1:0]    fl_eff;
    logic [FADE_W-1:0]    fr_eff;
    logic [RATIO_W-1:0]   step_eff;
    logic                 stereo_cfg;
    logic                 bypass;
    logic                 accept;
    logic [POS_W-1:0]     act_pos;
    logic [POS_W-1:0]     cur_pos;
    logic [IDX_W-1:0]     i0;
    logic [IDX_W-1:0]     i1;
    logic [LEN_W-1:0]     i1_wide;
    logic [15:0]          frac;
    logic [16:0]          w0;
    logic signed [TAP_W-2:0] p0_calc;
    logic signed [TAP_W-1:0] tap_calc;
    logic [GAIN_W-1:0]    gain_sel;
    logic signed [ACC_W-1:0] mix_sum;
    logic signed [ACC_W-1:0] fade_val;
    logic signed [ACC_W-1:0] plain_val;
    logic [POS_W-1:0]     wiq;
    logic [LQ_W-1:0]      dist_calc;
    logic [POS_W-1:0]     back;
    logic [LQ_W-1:0]      new_idle;
    logic [LEN_W-1:0]     wi_inc;
    logic                 restart;
    logic [LEN_W-1:0]     restart_len;

    // Memory and divider.
    logic                 mem_en;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [SAMPLE_BITS-1:0] mem_wdata;
    logic [SAMPLE_BITS-1:0] mem_rdata;
    logic                 div_start;
    div_status_t          div_status;
    logic [PHASE_W-1:0]   div_q;

    always_comb
    begin
        len_eff = clamp_len(delay_length_reg);
        lq      = {len_eff, 16'h0};

        if (int'(fade_length_reg) < int'(MIN_FADE))
            fl_eff = FADE_W'(MIN_FADE);
        else if (int'(fade_length_reg) > int'(MAX_FADE))
            fl_eff = FADE_W'(MAX_FADE);
        else
            fl_eff = fade_length_reg;
        fr_eff = (fade_rem_reg > fl_eff) ? fl_eff : fade_rem_reg;

        if (int'(pitch_ratio_reg) < int'(RATIO_MIN))
            step_eff = RATIO_W'(RATIO_MIN);
        else if (int'(pitch_ratio_reg) > int'(RATIO_MAX))
            step_eff = RATIO_W'(RATIO_MAX);
        else
            step_eff = pitch_ratio_reg;

        // Channel counts 2 and 3 mean stereo if MAX_CHANNELS > 1; else mono.
        stereo_cfg = channel_count_reg[1] && (MAX_CHANNELS > 1);
        bypass     = !enabled_reg || (int'(pitch_ratio_reg) == int'(RATIO_ONE));
        accept     = frame_valid && !frame_stall;

        act_pos = active_reg ? head_b_reg : head_a_reg;
        cur_pos = (active_reg ^ hsel_reg) ? head_b_reg : head_a_reg;
        i0      = ({1'b0, cur_pos[POS_W-1:16]} >= len_eff) ? '0 : cur_pos[POS_W-1:16];
        i1_wide = {1'b0, i0} + 1'b1;
        i1      = (i1_wide >= len_eff) ? '0 : i1_wide[IDX_W-1:0];
        frac    = cur_pos[15:0];
        w0      = 17'h10000 - {1'b0, frac};

        p0_calc  = v0_reg * $signed({1'b0, w0});
        tap_calc = p0_reg + v1_reg * $signed({1'b0, frac});

        // The active head takes the rising gain, the idle head the falling one.
        gain_sel  = hsel_reg ? g_old_reg : g_new_reg;
        mix_sum   = acc_reg + tap_reg * $signed({1'b0, gain_sel});
        fade_val  = (mix_sum + (ACC_W'(1) <<< 30)) >>> 31;
        plain_val = ACC_W'((tap_reg + TAP_W'(32768)) >>> 16);

        wiq = {wi_reg, 16'h0};
        if (wiq >= act_pos)
            dist_calc = LQ_W'(wiq - act_pos);
        else
            dist_calc = LQ_W'(wiq) + lq - LQ_W'(act_pos);

        // Jump target: a quarter of the line behind the write point.
        back = POS_W'({len_eff, 14'h0});
        if (wiq >= back)
            new_idle = LQ_W'(wiq - back);
        else
            new_idle = LQ_W'(wiq) + lq - LQ_W'(back);

        wi_inc = {1'b0, wi_reg} + 1'b1;

        restart     = 1'b0;
        restart_len = len_eff;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ENABLED:
                begin
                    restart = cfg_data[0] != enabled_reg;
                end
                CFG_DELAY_LENGTH:
                begin
                    restart_len = clamp_len(cfg_data[DLEN_W-1:0]);
                    restart     = restart_len != len_eff;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        div_start = accept && !bypass && (fr_eff != '0);
    end

    // Memory port: clearing pass, sample writes and tap reads.
    always_comb
    begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        if (clearing_reg)
        begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = clr_cnt_reg;
        end
        else
        begin
            case (state_reg)
                S_WRITE:
                begin
                    mem_en    = 1'b1;
                    mem_we    = 1'b1;
                    mem_addr  = addr_of(wi_reg, ch_reg);
                    mem_wdata = ch_reg ? s1_reg : s0_reg;
                end
                S_RD0:
                begin
                    mem_en   = 1'b1;
                    mem_addr = addr_of(i0, ch_reg);
                end
                S_RD1:
                begin
                    mem_en   = 1'b1;
                    mem_addr = addr_of(i1, ch_reg);
                end
                default:
                begin
                    mem_en = 1'b0;
                end
            endcase
        end
    end

    dlps_line_mem #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_line_mem (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    dlps_phase_div u_phase_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (fr_eff),
        .denom    (fl_eff),
        .status   (div_status),
        .quotient (div_q)
    );

    // Distance limits follow the line length; length changes restart the
    // line, so the limits have settled long before the next frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_base_reg <= '0;
            far_base_reg  <= '0;
            near_y_reg    <= '0;
            far_y_reg     <= '0;
            near_th_reg   <= '0;
            far_th_reg    <= '0;
        end
        else
        begin
            near_base_reg <= LQ_W'(64'(len_eff) * 64'(Q_NEAR));
            far_base_reg  <= LQ_W'(64'(len_eff) * 64'(Q_FAR));
            near_y_reg    <= TH_Y_W'(64'(len_eff) * 64'(R_NEAR));
            far_y_reg     <= TH_Y_W'(64'(len_eff) * 64'(R_FAR));
            near_th_reg   <= near_base_reg + LQ_W'((64'(near_y_reg) * RECIP) >> RECIP_SH);
            far_th_reg    <= far_base_reg + LQ_W'((64'(far_y_reg) * RECIP) >> RECIP_SH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg       <= 1'b0;
            pitch_ratio_reg   <= RATIO_W'(RATIO_ONE);
            channel_count_reg <= CHCNT_W'(1);
            delay_length_reg  <= DLEN_W'(MIN_LEN);
            fade_length_reg   <= FADE_W'(MIN_FADE);
            wi_reg            <= '0;
            head_a_reg        <= '0;
            head_b_reg        <= {IDX_W'(MIN_LEN / 2), 16'h0};
            fade_rem_reg      <= '0;
            active_reg        <= 1'b0;
            clearing_reg      <= 1'b1;
            clr_cnt_reg       <= '0;
            state_reg         <= S_IDLE;
            s0_reg            <= '0;
            s1_reg            <= '0;
            be_reg            <= 1'b0;
            stereo_reg        <= 1'b0;
            fading_reg        <= 1'b0;
            ch_reg            <= 1'b0;
            hsel_reg          <= 1'b0;
            v0_reg            <= '0;
            v1_reg            <= '0;
            p0_reg            <= '0;
            tap_reg           <= '0;
            acc_reg           <= '0;
            g_old_reg         <= '0;
            g_new_reg         <= '0;
            dist_reg          <= '0;
            res0_reg          <= '0;
            res1_reg          <= '0;
            result_valid_reg  <= 1'b0;
            result_reg        <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (int'(clr_cnt_reg) == MEM_DEPTH - 1)
                begin
                    clearing_reg <= 1'b0;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        s0_reg     <= frame.sample_ch0;
                        s1_reg     <= frame.sample_ch1;
                        be_reg     <= frame.block_end;
                        stereo_reg <= stereo_cfg;
                        fading_reg <= fr_eff != '0;
                        ch_reg     <= 1'b0;
                        hsel_reg   <= 1'b0;
                        res1_reg   <= '0;
                        if (bypass)
                        begin
                            res0_reg  <= frame.sample_ch0;
                            if (stereo_cfg)
                                res1_reg <= frame.sample_ch1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_WRITE:
                begin
                    if (!ch_reg && stereo_reg)
                    begin
                        ch_reg <= 1'b1;
                    end
                    else
                    begin
                        ch_reg    <= 1'b0;
                        state_reg <= fading_reg ? S_GAIN : S_RD0;
                    end
                end
                S_GAIN:
                begin
                    if (div_status.done)
                    begin
                        g_old_reg <= gain(div_q);
                        g_new_reg <= gain(17'h10000 - div_q);
                        state_reg <= S_RD0;
                    end
                end
                S_RD0:
                begin
                    state_reg <= S_RD1;
                end
                S_RD1:
                begin
                    v0_reg    <= $signed(mem_rdata);
                    state_reg <= S_RD2;
                end
                S_RD2:
                begin
                    p0_reg    <= p0_calc;
                    v1_reg    <= $signed(mem_rdata);
                    state_reg <= S_RD3;
                end
                S_RD3:
                begin
                    tap_reg   <= tap_calc;
                    state_reg <= S_MIX;
                end
                S_MIX:
                begin
                    if (fading_reg && !hsel_reg)
                    begin
                        // First pass of a crossfade: keep the active tap.
                        acc_reg   <= mix_sum;
                        hsel_reg  <= 1'b1;
                        state_reg <= S_RD0;
                    end
                    else
                    begin
                        if (ch_reg)
                            res1_reg <= sat(fading_reg ? fade_val : plain_val);
                        else
                            res0_reg <= sat(fading_reg ? fade_val : plain_val);
                        acc_reg  <= '0;
                        hsel_reg <= 1'b0;
                        if (!ch_reg && stereo_reg)
                        begin
                            ch_reg    <= 1'b1;
                            state_reg <= S_RD0;
                        end
                        else
                        begin
                            ch_reg    <= 1'b0;
                            state_reg <= S_UPD1;
                        end
                    end
                end
                S_UPD1:
                begin
                    head_a_reg   <= advance(head_a_reg, step_eff, lq);
                    head_b_reg   <= advance(head_b_reg, step_eff, lq);
                    fade_rem_reg <= (fr_eff != '0) ? fr_eff - 1'b1 : '0;
                    state_reg    <= S_UPD2;
                end
                S_UPD2:
                begin
                    dist_reg  <= dist_calc;
                    state_reg <= S_UPD3;
                end
                S_UPD3:
                begin
                    // Head too close to or too far behind the write point:
                    // place the idle head and fade to it if no fade is running.
                    if (((dist_reg < near_th_reg) || (dist_reg > far_th_reg)) &&
                        (fade_rem_reg == '0))
                    begin
                        if (active_reg)
                            head_a_reg <= new_idle[POS_W-1:0];
                        else
                            head_b_reg <= new_idle[POS_W-1:0];
                        active_reg   <= !active_reg;
                        fade_rem_reg <= fl_eff;
                    end
                    wi_reg    <= (wi_inc >= len_eff) ? '0 : wi_inc[IDX_W-1:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.out_ch0       <= res0_reg;
                        result_reg.out_ch1       <= res1_reg;
                        result_reg.block_end_out <= be_reg;
                        result_valid_reg         <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // User sends configuration writes only with no frame in flight.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ENABLED:       enabled_reg       <= cfg_data[0];
                    CFG_PITCH_RATIO:   pitch_ratio_reg   <= cfg_data[RATIO_W-1:0];
                    CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHCNT_W-1:0];
                    CFG_DELAY_LENGTH:  delay_length_reg  <= cfg_data[DLEN_W-1:0];
                    CFG_FADE_LENGTH:   fade_length_reg   <= cfg_data[FADE_W-1:0];
                    default:           enabled_reg       <= enabled_reg;
                endcase
            end

            if (restart)
            begin
                wi_reg       <= '0;
                head_a_reg   <= '0;
                head_b_reg   <= {restart_len[IDX_W:1], 16'h0};
                fade_rem_reg <= '0;
                active_reg   <= 1'b0;
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
        end
    end

    assign frame_stall  = (state_reg != S_IDLE) || clearing_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `DLPS_CHECK(clear_only_idle, clk, rst_n, clearing_reg, (state_reg == S_IDLE))
    `DLPS_CHECK(gains_ready, clk, rst_n, (state_reg == S_MIX && fading_reg), div_status.done)
    `DLPS_CHECK(wi_in_line, clk, rst_n, 1'b1, ({1'b0, wi_reg} < len_eff))
    `DLPS_CHECK_NEXT(done_loads, clk, rst_n, (state_reg == S_DONE && (!result_valid_reg || !result_stall)), (result_valid_reg && state_reg == S_IDLE))

endmodule
